// ===== sv/lwsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lwsc_pkg
// Shared types and constants of the write-back sector cache tag engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lwsc_pkg;

  // default slot count and fixed field widths
  localparam int unsigned LinesDef = 64;
  localparam int unsigned SectorW  = 32;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned RankW    = 6;
  localparam int unsigned OpW      = 2;

  // request codes
  typedef enum logic [OpW-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_APPLY  = 2'd2,
    ST_FLUSH  = 2'd3
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;
    logic search;
    logic apply;
    logic flush_step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic flush_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/lru_writeback_sector_cache.sv =====
// ----------------------------------------------------------------------------
// lru_writeback_sector_cache
// Tag and LRU replacement engine of a fully associative write-back sector
// cache.
//
//   channel   direction  handshake             payload
//   request   in         in_valid / in_ready   opcode, sector
//   result    out        out_valid / out_ready slot, hit, fetch, writeback,
//                                              writeback_sector, last
//
// A read or write passes accept, tag search and apply before its result is
// registered; a flush gives one result per slot, one per cycle if not held.
// One request is in the engine at a time; the next is taken once it is done.
// A full result register holds the engine in apply or flush until taken.
// Reset clears valid, dirty and recency marks at once; tags are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_writeback_sector_cache
  import lwsc_pkg::*;
#(
  parameter int unsigned LINES = LinesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [SectorW-1:0] sector_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SlotW-1:0]   slot_o,
  output logic               hit_o,
  output logic               fetch_o,
  output logic               writeback_o,
  output logic [SectorW-1:0] writeback_sector_o,
  output logic               last_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  lwsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and result datapath
  lwsc_dp #(.LINES(LINES)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .opcode_i           (opcode_i),
    .sector_i           (sector_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .slot_o             (slot_o),
    .hit_o              (hit_o),
    .fetch_o            (fetch_o),
    .writeback_o        (writeback_o),
    .writeback_sector_o (writeback_sector_o),
    .last_o             (last_o)
  );

endmodule

`default_nettype wire

// ===== sv/lwsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lwsc_ctrl
// Sequencer: takes a request word, walks it through search and apply, or
// steps a flush over all slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lwsc_ctrl
  import lwsc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [OpW-1:0] opcode_i,
  output logic           in_ready_o,
  input  sts_t           sts_i,
  output cmd_t           cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_READ || opcode_i == OP_WRITE) begin
            state_d = ST_SEARCH;
          end else if (opcode_i == OP_FLUSH) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_SEARCH: state_d = ST_APPLY;
      ST_APPLY: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_FLUSH: begin
        if (sts_i.out_free && sts_i.flush_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = accept;
      end
      ST_SEARCH: cmd_o.search = 1'b1;
      ST_APPLY:  cmd_o.apply = sts_i.out_free;
      ST_FLUSH:  cmd_o.flush_step = sts_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/lwsc_dp.sv =====
// ----------------------------------------------------------------------------
// lwsc_dp
// Tag, valid, dirty and recency storage with parallel tag compare, slot
// choice, recency update and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lwsc_dp
  import lwsc_pkg::*;
#(
  parameter int unsigned LINES = LinesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [SectorW-1:0] sector_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SlotW-1:0]   slot_o,
  output logic               hit_o,
  output logic               fetch_o,
  output logic               writeback_o,
  output logic [SectorW-1:0] writeback_sector_o,
  output logic               last_o
);

  localparam int unsigned IdxW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(LINES - 1);
  localparam logic [RankW-1:0] OldRank = RankW'(LINES - 1);

  // state storage
  logic [SectorW-1:0] tag_q  [LINES];
  logic [RankW-1:0]   rank_q [LINES];
  logic [LINES-1:0]   valid_q;
  logic [LINES-1:0]   dirty_q;

  // request word
  logic               wr_q;
  logic [SectorW-1:0] sec_q;
  logic [IdxW-1:0]    fidx_q;

  // search results
  logic               hit_q, wb_q;
  logic [IdxW-1:0]    sel_q;
  logic [RankW:0]     old_q;
  logic [SectorW-1:0] wbs_q;

  // result register
  logic               ov_q;
  logic [SlotW-1:0]   slot_q;
  logic               hit_r_q, fetch_q, wbo_q, last_q;
  logic [SectorW-1:0] wbso_q;

  // parallel compare with lowest-index priority
  logic               m_hit, m_free;
  logic [IdxW-1:0]    hit_idx, free_idx, vic_idx, sel_d;
  always_comb begin
    m_hit    = 1'b0;
    m_free   = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    vic_idx  = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == sec_q) begin
        m_hit   = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        m_free   = 1'b1;
        free_idx = IdxW'(i);
      end
      if (rank_q[i] == OldRank) vic_idx = IdxW'(i);
    end
    sel_d = m_hit ? hit_idx : (m_free ? free_idx : vic_idx);
  end

  // handshake status
  assign sts_o.out_free   = !ov_q || out_ready_i;
  assign sts_o.flush_last = (fidx_q == LastIdx);

  // request capture and search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      wr_q  <= (opcode_i == OP_WRITE);
      sec_q <= sector_i;
    end
    if (cmd_i.search) begin
      hit_q  <= m_hit;
      sel_q  <= sel_d;
      old_q  <= (!m_hit && m_free) ? (RankW + 1)'(1 << RankW) : {1'b0, rank_q[sel_d]};
      wb_q   <= !m_hit && !m_free && dirty_q[sel_d];
      wbs_q  <= tag_q[sel_d];
    end
  end

  // flush slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fidx_q <= '0;
    end else if (cmd_i.load_req) begin
      fidx_q <= '0;
    end else if (cmd_i.flush_step && fidx_q != LastIdx) begin
      fidx_q <= fidx_q + 1'b1;
    end
  end

  // tag store, written on apply
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) tag_q[sel_q] <= sec_q;
  end

  // valid, dirty and recency update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int i = 0; i < LINES; i++) rank_q[i] <= '0;
    end else if (cmd_i.apply) begin
      valid_q[sel_q] <= 1'b1;
      dirty_q[sel_q] <= hit_q ? (dirty_q[sel_q] | wr_q) : wr_q;
      for (int i = 0; i < LINES; i++) begin
        if (IdxW'(i) == sel_q) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && {1'b0, rank_q[i]} < old_q) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
    end else if (cmd_i.flush_step) begin
      dirty_q[fidx_q] <= 1'b0;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.apply || cmd_i.flush_step) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      slot_q  <= SlotW'(sel_q);
      hit_r_q <= hit_q;
      fetch_q <= !hit_q && !wr_q;
      wbo_q   <= wb_q;
      wbso_q  <= wb_q ? wbs_q : '0;
      last_q  <= 1'b1;
    end else if (cmd_i.flush_step) begin
      slot_q  <= SlotW'(fidx_q);
      hit_r_q <= 1'b0;
      fetch_q <= 1'b0;
      wbo_q   <= valid_q[fidx_q] && dirty_q[fidx_q];
      wbso_q  <= (valid_q[fidx_q] && dirty_q[fidx_q]) ? tag_q[fidx_q] : '0;
      last_q  <= (fidx_q == LastIdx);
    end
  end

  assign out_valid_o        = ov_q;
  assign slot_o             = slot_q;
  assign hit_o              = hit_r_q;
  assign fetch_o            = fetch_q;
  assign writeback_o        = wbo_q;
  assign writeback_sector_o = wbso_q;
  assign last_o             = last_q;

endmodule

`default_nettype wire

// ===== sv/lwsc_checker.sv =====
// ----------------------------------------------------------------------------
// lwsc_checker
// Port-level checks of the sector cache tag engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lwsc_checker
  import lwsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic [OpW-1:0]     opcode_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [SlotW-1:0]   slot_o,
  input  logic               hit_o,
  input  logic               fetch_o,
  input  logic               writeback_o,
  input  logic [SectorW-1:0] writeback_sector_o
);

  // a stalled result stays valid and keeps its slot
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_o))
    else $error("result changed while stalled");

  // a hit needs no device traffic
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !fetch_o && !writeback_o)
    else $error("hit with fetch or writeback");

  // no write-back means sector reads zero
  a_wbs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !writeback_o |-> writeback_sector_o == '0)
    else $error("stray writeback sector");

  // an accepted word closes the input for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == OP_READ || opcode_i == OP_WRITE ||
    opcode_i == OP_FLUSH) |=> !in_ready_o)
    else $error("input taken while busy");

endmodule

bind lru_writeback_sector_cache lwsc_checker u_lwsc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .opcode_i           (opcode_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .slot_o             (slot_o),
  .hit_o              (hit_o),
  .fetch_o            (fetch_o),
  .writeback_o        (writeback_o),
  .writeback_sector_o (writeback_sector_o)
);

`default_nettype wire
